>>> rtl/core/hpt_pkg.sv
`default_nettype none

package hpt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NUM_PAIRS = 8;
    localparam int IDX_W     = 3;
    localparam int COEF_W    = 32;
    localparam int PAIR_W    = 64;
    localparam int PROD_W    = 64;
    localparam int SUM_W     = 66;
    localparam int DOT_W     = SUM_W + 1 - FRAC_BITS;
    localparam int NUM_W     = 64;
    localparam int QUO_W     = 33;
    localparam int CMP_W     = DOT_W + QUO_W + 1;
    localparam int DIV_STAGES = QUO_W + 1;
    localparam int NUM_LANES = 3;
    localparam int NUM_ROWS  = 4;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;

    localparam logic [COEF_W-1:0] ONE_C = COEF_W'(1) << FRAC_BITS;
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);

    typedef logic [PAIR_W-1:0] t_pair;
    typedef t_pair [NUM_PAIRS-1:0] t_coef;
    typedef logic signed [DOT_W-1:0] t_dot;

    localparam t_coef COEF_RST = '{
        7: {ONE_C, COEF_W'(0)},
        5: {COEF_W'(0), ONE_C},
        2: {ONE_C, COEF_W'(0)},
        0: {COEF_W'(0), ONE_C},
        default: '0
    };

    localparam t_dot DOT_ONE = t_dot'(ONE_C);
    localparam t_dot DOT_MAX = t_dot'({1'b0, {(COEF_W-1){1'b1}}});
    localparam t_dot DOT_MIN = ~DOT_MAX;
    localparam logic [COEF_W-1:0] OUT_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] OUT_MIN = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic [QUO_W-1:0] Q_POS_LIM = QUO_W'(OUT_MAX);
    localparam logic [QUO_W-1:0] Q_NEG_LIM = QUO_W'(OUT_MIN);

    typedef struct packed {
        t_dot x;
        t_dot y;
        t_dot z;
        t_dot w;
        logic div;
    } t_work;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic signed [COEF_W-1:0] elem(input t_coef c, input logic [3:0] idx);
        elem = idx[0] ? c[idx[3:1]][PAIR_W-1:COEF_W] : c[idx[3:1]][COEF_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/homogeneous_point_transform.sv
// Transforms one Q16.16 point per request by a column-major 4x4 matrix held in eight
// 64-bit coefficient registers (identity after reset). Point mode adds the translation
// and divides by w unless w is zero or exactly one; vector mode uses the upper 3x3 part.
// The block takes one request every clock cycle while o_stall is low; the restoring divider,
// one quotient bit per stage, follows the three-stage multiply and sum pipeline and a
// four-entry queue.
`default_nettype none

module homogeneous_point_transform import hpt_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_action,
    input  logic signed [COEF_W-1:0] i_in_x,
    input  logic signed [COEF_W-1:0] i_in_y,
    input  logic signed [COEF_W-1:0] i_in_z,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [COEF_W-1:0] o_out_x,
    output logic signed [COEF_W-1:0] o_out_y,
    output logic signed [COEF_W-1:0] o_out_z,
    output logic                     o_did_divide,
    output logic                     o_saturated,
    input  logic                     i_cfg_we,
    input  logic [IDX_W-1:0]         i_cfg_idx,
    input  logic [PAIR_W-1:0]        i_cfg_data
);

    t_coef   r_coef;
    logic    push;
    logic    pop;
    t_work   push_data;
    t_work   pop_data;
    t_q_stat q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= COEF_RST;
        end else if (i_cfg_we) begin
            r_coef[i_cfg_idx] <= i_cfg_data;
        end
    end

    hpt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_action (i_action),
        .i_in_x   (i_in_x),
        .i_in_y   (i_in_y),
        .i_in_z   (i_in_z),
        .i_coef   (r_coef),
        .o_push   (push),
        .o_entry  (push_data),
        .i_q_stat (q_stat)
    );

    hpt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (pop_data),
        .o_stat  (q_stat)
    );

    hpt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_entry      (pop_data),
        .i_q_stat     (q_stat),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_z      (o_out_z),
        .o_did_divide (o_did_divide),
        .o_saturated  (o_saturated)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_stat.full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && q_stat.empty))
        else $error("queue read while empty");

endmodule

`default_nettype wire

>>> rtl/core/hpt_front.sv
`default_nettype none

module hpt_front import hpt_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_action,
    input  logic signed [COEF_W-1:0] i_in_x,
    input  logic signed [COEF_W-1:0] i_in_y,
    input  logic signed [COEF_W-1:0] i_in_z,
    input  t_coef                    i_coef,
    output logic                     o_push,
    output t_work                    o_entry,
    input  t_q_stat                  i_q_stat
);

    logic adv;
    logic take;
    logic r_v1, r_v2, r_v3;
    logic signed [PROD_W-1:0] r_p [NUM_ROWS][NUM_LANES];
    logic signed [COEF_W-1:0] r_t1 [NUM_ROWS];
    logic signed [COEF_W-1:0] r_t2 [NUM_ROWS];
    logic r_act1, r_act2;
    logic signed [SUM_W-1:0] r_s [NUM_ROWS];
    logic signed [COEF_W-1:0] vin [NUM_LANES];
    t_dot dots [NUM_ROWS];
    t_work n_e;
    t_work r_e;

    assign adv     = !r_v3 || !i_q_stat.full;
    assign o_stall = !adv;
    assign take    = i_valid && adv;
    assign o_push  = r_v3 && !i_q_stat.full;
    assign o_entry = r_e;

    assign vin[0] = i_in_x;
    assign vin[1] = i_in_y;
    assign vin[2] = i_in_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= take;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            dots[r] = t_dot'(r_s[r] >>> FRAC_BITS) + t_dot'(r_t2[r]);
        end
        n_e.x   = dots[0];
        n_e.y   = dots[1];
        n_e.z   = dots[2];
        n_e.w   = dots[3];
        n_e.div = !r_act2 && (dots[3] != '0) && (dots[3] != DOT_ONE);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                for (int k = 0; k < NUM_LANES; k++) begin
                    r_p[r][k] <= vin[k] * elem(i_coef, 4'(r + 4 * k));
                end
                r_t1[r] <= (i_action && r < NUM_LANES) ? '0 : elem(i_coef, 4'(12 + r));
                r_s[r]  <= SUM_W'(r_p[r][0]) + SUM_W'(r_p[r][1]) + SUM_W'(r_p[r][2]) + HALF;
                r_t2[r] <= r_t1[r];
            end
            r_act1 <= i_action;
            r_act2 <= r_act1;
            r_e    <= n_e;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/hpt_queue.sv
`default_nettype none

module hpt_queue import hpt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_work   i_data,
    input  logic    i_pop,
    output t_work   o_data,
    output t_q_stat o_stat
);

    t_work r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_stat.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_data       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/hpt_back.sv
`default_nettype none

module hpt_back import hpt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_work             i_entry,
    input  t_q_stat           i_q_stat,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [COEF_W-1:0] o_out_x,
    output logic [COEF_W-1:0] o_out_y,
    output logic [COEF_W-1:0] o_out_z,
    output logic              o_did_divide,
    output logic              o_saturated
);

    logic en;
    t_dot val [NUM_LANES];
    logic [DOT_W-1:0] an [NUM_LANES];
    logic [DOT_W+FRAC_BITS-1:0] shl [NUM_LANES];
    logic [DOT_W-1:0] aw;
    logic [COEF_W-1:0] cval [NUM_LANES];
    logic csat [NUM_LANES];

    logic r_b_v;
    logic [NUM_W-1:0] r_b_num [NUM_LANES];
    logic r_b_neg [NUM_LANES];
    logic [COEF_W-1:0] r_b_clip [NUM_LANES];
    logic r_b_csat [NUM_LANES];
    logic [DOT_W-1:0] r_b_aw;
    logic r_b_div;

    logic r_vs [DIV_STAGES];
    logic [NUM_W-1:0] r_rem [DIV_STAGES][NUM_LANES];
    logic [QUO_W-1:0] r_q [DIV_STAGES][NUM_LANES];
    logic r_ovf [DIV_STAGES][NUM_LANES];
    logic r_neg [DIV_STAGES][NUM_LANES];
    logic [COEF_W-1:0] r_clip [DIV_STAGES][NUM_LANES];
    logic r_csat [DIV_STAGES][NUM_LANES];
    logic [DOT_W-1:0] r_aw [DIV_STAGES];
    logic r_div [DIV_STAGES];

    logic [COEF_W-1:0] fval [NUM_LANES];
    logic fsat [NUM_LANES];
    logic r_ov;
    logic [COEF_W-1:0] r_ox, r_oy, r_oz;
    logic r_odiv, r_osat;

    assign en      = !r_ov || !i_stall;
    assign o_pop   = en && !i_q_stat.empty;
    assign o_valid = r_ov;
    assign o_out_x = r_ox;
    assign o_out_y = r_oy;
    assign o_out_z = r_oz;
    assign o_did_divide = r_odiv;
    assign o_saturated  = r_osat;

    assign val[0] = i_entry.x;
    assign val[1] = i_entry.y;
    assign val[2] = i_entry.z;
    assign aw = i_entry.w[DOT_W-1] ? DOT_W'(-i_entry.w) : DOT_W'(i_entry.w);

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            an[l]  = val[l][DOT_W-1] ? DOT_W'(-val[l]) : DOT_W'(val[l]);
            shl[l] = {an[l], {FRAC_BITS{1'b0}}};
            if (val[l] > DOT_MAX) begin
                cval[l] = OUT_MAX;
                csat[l] = 1'b1;
            end else if (val[l] < DOT_MIN) begin
                cval[l] = OUT_MIN;
                csat[l] = 1'b1;
            end else begin
                cval[l] = val[l][COEF_W-1:0];
                csat[l] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                r_b_num[l]  <= shl[l][NUM_W-1:0];
                r_b_neg[l]  <= val[l][DOT_W-1] ^ i_entry.w[DOT_W-1];
                r_b_clip[l] <= cval[l];
                r_b_csat[l] <= csat[l];
            end
            r_b_aw  <= aw;
            r_b_div <= i_entry.div;
            for (int l = 0; l < NUM_LANES; l++) begin
                r_rem[0][l]  <= r_b_num[l];
                r_q[0][l]    <= '0;
                r_ovf[0][l]  <= CMP_W'(r_b_num[l]) >= CMP_W'({r_b_aw, {QUO_W{1'b0}}});
                r_neg[0][l]  <= r_b_neg[l];
                r_clip[0][l] <= r_b_clip[l];
                r_csat[0][l] <= r_b_csat[l];
            end
            r_aw[0]  <= r_b_aw;
            r_div[0] <= r_b_div;
        end
    end

    for (genvar s = 1; s < DIV_STAGES; s++) begin : g_stage
        localparam int BIT = QUO_W - s;
        logic [CMP_W-1:0] d;
        logic ge [NUM_LANES];
        assign d = CMP_W'(r_aw[s-1]) << BIT;
        always_comb begin
            for (int l = 0; l < NUM_LANES; l++) begin
                ge[l] = CMP_W'(r_rem[s-1][l]) >= d;
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int l = 0; l < NUM_LANES; l++) begin
                    r_rem[s][l] <= ge[l] ? NUM_W'(CMP_W'(r_rem[s-1][l]) - d) : r_rem[s-1][l];
                    r_q[s][l]   <= r_q[s-1][l] | (QUO_W'(ge[l]) << BIT);
                    r_ovf[s][l]  <= r_ovf[s-1][l];
                    r_neg[s][l]  <= r_neg[s-1][l];
                    r_clip[s][l] <= r_clip[s-1][l];
                    r_csat[s][l] <= r_csat[s-1][l];
                end
                r_aw[s]  <= r_aw[s-1];
                r_div[s] <= r_div[s-1];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            if (!r_div[DIV_STAGES-1]) begin
                fval[l] = r_clip[DIV_STAGES-1][l];
                fsat[l] = r_csat[DIV_STAGES-1][l];
            end else if (r_ovf[DIV_STAGES-1][l]) begin
                fval[l] = r_neg[DIV_STAGES-1][l] ? OUT_MIN : OUT_MAX;
                fsat[l] = 1'b1;
            end else if (!r_neg[DIV_STAGES-1][l] && r_q[DIV_STAGES-1][l] > Q_POS_LIM) begin
                fval[l] = OUT_MAX;
                fsat[l] = 1'b1;
            end else if (r_neg[DIV_STAGES-1][l] && r_q[DIV_STAGES-1][l] > Q_NEG_LIM) begin
                fval[l] = OUT_MIN;
                fsat[l] = 1'b1;
            end else begin
                fval[l] = r_neg[DIV_STAGES-1][l] ? COEF_W'(QUO_W'(0) - r_q[DIV_STAGES-1][l])
                                                 : r_q[DIV_STAGES-1][l][COEF_W-1:0];
                fsat[l] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ox   <= fval[0];
            r_oy   <= fval[1];
            r_oz   <= fval[2];
            r_odiv <= r_div[DIV_STAGES-1];
            r_osat <= fsat[0] || fsat[1] || fsat[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
            r_ov  <= 1'b0;
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_vs[s] <= 1'b0;
            end
        end else if (en) begin
            r_b_v   <= o_pop;
            r_vs[0] <= r_b_v;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_vs[s] <= r_vs[s-1];
            end
            r_ov <= r_vs[DIV_STAGES-1];
        end
    end

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 100ps
`default_nettype none

module tb;
    import hpt_pkg::*;

    localparam logic ACT_POINT  = 1'b0;
    localparam logic ACT_VECTOR = 1'b1;
    localparam int   LATENCY    = 60;
    localparam longint CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic        action;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_req;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        div;
        logic        sat;
    } t_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_action;
    logic [31:0] i_in_x, i_in_y, i_in_z;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_out_x, o_out_y, o_out_z;
    logic        o_did_divide, o_saturated;
    logic        i_cfg_we;
    logic [IDX_W-1:0]  i_cfg_idx;
    logic [PAIR_W-1:0] i_cfg_data;

    homogeneous_point_transform dut (.*);

    t_req   pending_reqs[$];
    t_res   expected_points[$];
    logic [63:0] matrix_regs[NUM_PAIRS];
    int     errors;
    int     send_idle_pct, recv_idle_pct;
    int     hold_off;
    longint cycles;

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic longint matrix_elem(int i);
        logic [63:0] p;
        p = matrix_regs[i >> 1];
        return (i & 1) ? longint'(signed'(p[63:32])) : longint'(signed'(p[31:0]));
    endfunction

    function automatic longint round_dot(longint v[3], int e0, longint t);
        logic signed [127:0] acc;
        int k;
        acc = 0;
        for (k = 0; k < 3; k++)
            acc += 128'(signed'(v[k])) * 128'(signed'(matrix_elem(e0 + 4 * k)));
        acc += 128'sd1 <<< (FRAC_BITS - 1);
        acc = acc >>> FRAC_BITS;
        return longint'(acc) + t;
    endfunction

    function automatic logic [31:0] clip_word(longint v, inout logic sat);
        if (v > 64'sh7FFFFFFF) begin
            sat = 1'b1;
            return 32'h7FFFFFFF;
        end
        if (v < -64'sh80000000) begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] divide_by_w(longint num, longint w, inout logic sat);
        logic [127:0] an, aw, q;
        logic neg;
        an = num < 0 ? 128'(-num) : 128'(num);
        aw = w < 0 ? 128'(-w) : 128'(w);
        neg = (num < 0) != (w < 0);
        q = (an << FRAC_BITS) / aw;
        if (!neg && q > 128'h7FFFFFFF) begin
            sat = 1'b1;
            return 32'h7FFFFFFF;
        end
        if (neg && q > 128'h80000000) begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return neg ? 32'(-q) : q[31:0];
    endfunction

    function automatic t_res transform_point(t_req r);
        t_res res;
        longint v[3];
        longint x, y, z, w;
        logic sat, div;
        sat = 1'b0;
        div = 1'b0;
        v[0] = longint'(signed'(r.x));
        v[1] = longint'(signed'(r.y));
        v[2] = longint'(signed'(r.z));
        if (r.action == ACT_VECTOR) begin
            x = round_dot(v, 0, 0);
            y = round_dot(v, 1, 0);
            z = round_dot(v, 2, 0);
            w = 0;
        end else begin
            x = round_dot(v, 0, matrix_elem(12));
            y = round_dot(v, 1, matrix_elem(13));
            z = round_dot(v, 2, matrix_elem(14));
            w = round_dot(v, 3, matrix_elem(15));
            div = (w != 0) && (w != (longint'(1) << FRAC_BITS));
        end
        if (div) begin
            res.x = divide_by_w(x, w, sat);
            res.y = divide_by_w(y, w, sat);
            res.z = divide_by_w(z, w, sat);
        end else begin
            res.x = clip_word(x, sat);
            res.y = clip_word(y, sat);
            res.z = clip_word(z, sat);
        end
        res.div = div;
        res.sat = sat;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // Driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t_req r;
                r = pending_reqs.pop_front();
                expected_points.push_back(transform_point(r));
                i_valid  <= 1'b1;
                i_action <= r.action;
                i_in_x   <= r.x;
                i_in_y   <= r.y;
                i_in_z   <= r.z;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver stall, with an optional long hold-off.
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_stall  <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout");
            $display("FAILED: results differ");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_points.size() == 0) begin
                report_mismatch("unexpected result", o_out_x, 32'h0);
            end else begin
                t_res e;
                e = expected_points.pop_front();
                if (o_out_x !== e.x) report_mismatch("out_x", o_out_x, e.x);
                if (o_out_y !== e.y) report_mismatch("out_y", o_out_y, e.y);
                if (o_out_z !== e.z) report_mismatch("out_z", o_out_z, e.z);
                if (o_did_divide !== e.div)
                    report_mismatch("did_divide", 32'(o_did_divide), 32'(e.div));
                if (o_saturated !== e.sat)
                    report_mismatch("saturated", 32'(o_saturated), 32'(e.sat));
            end
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'(signed'($urandom_range(2000)) - 1000) <<< 16;
            2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            3: return ($urandom_range(1)) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'(signed'($urandom_range(200000)) - 100000) <<< 4;
        endcase
    endfunction

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'(signed'($urandom_range(8)) - 4) <<< 16;
            2: return {16'($urandom_range(1) ? 16'hFFFF : 16'h0000), 16'($urandom())};
            3: return ($urandom_range(1)) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'(signed'($urandom_range(4000)) - 2000) <<< 6;
        endcase
    endfunction

    task automatic write_reg(int idx, logic [63:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= IDX_W'(idx);
        i_cfg_data <= value;
        matrix_regs[idx] = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || expected_points.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic queue_random(int n);
        t_req r;
        repeat (n) begin
            r.action = ($urandom_range(3) == 0) ? ACT_VECTOR : ACT_POINT;
            r.x = rand_coord();
            r.y = rand_coord();
            r.z = rand_coord();
            pending_reqs.push_back(r);
        end
    endtask

    task automatic queue_req(logic a, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_req r;
        r = '{action: a, x: x, y: y, z: z};
        pending_reqs.push_back(r);
    endtask

    task automatic load_matrix(int style);
        int k;
        for (k = 0; k < NUM_PAIRS; k++) begin
            case (style)
                0: write_reg(k, {$urandom(), $urandom()});
                1: write_reg(k, (k[0]) ? 64'h80000000_7FFFFFFF : 64'h7FFFFFFF_80000000);
                default: write_reg(k, {rand_coef(), rand_coef()});
            endcase
        end
        // Keep w usable for most points: a small whole-number w offset.
        if (style == 2) write_reg(7, {32'(signed'($urandom_range(6)) - 3) <<< 16, rand_coef()});
    endtask

    initial begin
        int k, ph;
        errors = 0;
        cycles = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_action = ACT_POINT;
        i_in_x = '0;
        i_in_y = '0;
        i_in_z = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        for (k = 0; k < NUM_PAIRS; k++) matrix_regs[k] = COEF_RST[k];
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests against the identity matrix.
        queue_req(ACT_POINT, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        queue_req(ACT_VECTOR, 32'h7FFFFFFF, 32'h80000000, 32'h0);
        queue_req(ACT_POINT, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        queue_req(ACT_POINT, 32'h80000000, 32'h80000000, 32'h80000000);
        queue_req(ACT_POINT, 32'hFFFFFFFF, 32'h00000001, 32'h0);
        wait_drained();

        // w becomes zero, then equals x, then one exactly, then two, then just below zero.
        write_reg(7, {32'h0, 32'h0});
        queue_req(ACT_POINT, 32'h0, 32'h0, 32'h0);
        queue_req(ACT_POINT, 32'h0005_0000, 32'h0, 32'h0);
        wait_drained();
        write_reg(1, {32'h0001_0000, 32'h0});
        queue_req(ACT_POINT, 32'h0005_0000, 32'h0, 32'h0);
        wait_drained();
        write_reg(1, {32'h0, 32'h0});
        write_reg(7, {32'h0001_0000, 32'h0});
        queue_req(ACT_POINT, 32'h0, 32'h0, 32'h0003_0000);
        queue_req(ACT_VECTOR, 32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF);
        wait_drained();
        write_reg(7, {32'h0002_0000, 32'h0007_0000});
        queue_req(ACT_POINT, 32'h7FFF_0000, 32'h8000_0000, 32'h0001_8000);
        queue_req(ACT_POINT, 32'h0, 32'h0, 32'h8000_0000);
        wait_drained();
        write_reg(7, {32'hFFFF_FFFF, 32'h0});
        queue_req(ACT_POINT, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        queue_req(ACT_POINT, 32'h0000_0001, 32'h0, 32'h0);
        wait_drained();

        // Extreme matrices.
        load_matrix(1);
        queue_req(ACT_POINT, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
        queue_req(ACT_VECTOR, 32'h80000000, 32'h80000000, 32'h80000000);
        queue_req(ACT_POINT, 32'h00010000, 32'hFFFF0000, 32'h0);
        wait_drained();

        for (ph = 0; ph < 6; ph++) begin
            case (ph % 3)
                0: begin send_idle_pct = 8;  recv_idle_pct = 86; end
                1: begin send_idle_pct = 86; recv_idle_pct = 8;  end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            load_matrix(ph == 3 ? 0 : 2);
            if (ph == 2) hold_off = 300;
            queue_random(200);
            wait_drained();
        end

        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

`default_nettype wire

>>> filelist.f
rtl/core/hpt_pkg.sv
rtl/core/hpt_front.sv
rtl/core/hpt_queue.sv
rtl/core/hpt_back.sv
rtl/core/homogeneous_point_transform.sv
verif/tb.sv
